/* src/crc32wbs_pkg.sv */
// Shared constants and the CRC-32 word-step matrix for the byte-stream CRC core.
package crc32wbs_pkg;

  localparam int unsigned CrcWidth  = 32;
  localparam int unsigned ByteWidth = 8;

  localparam logic [CrcWidth-1:0] CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [CrcWidth-1:0] CRC_XOROUT = 32'hFFFF_FFFF;
  localparam logic [CrcWidth-1:0] CRC_POLY   = 32'h04C1_1DB7;

  typedef logic [CrcWidth-1:0] crc_word_t;
  typedef crc_word_t crc_mat_t [CrcWidth];

  // Image of one set input bit after 32 MSB-first shifts. The word step is
  // linear over GF(2), so the full step is the XOR of these columns.
  function automatic crc_word_t crc_column(input int unsigned bit_idx);
    crc_word_t r;
    r = crc_word_t'(1) << bit_idx;
    for (int unsigned k = 0; k < CrcWidth; k++) begin
      if (r[CrcWidth-1]) begin
        r = (r << 1) ^ CRC_POLY;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

  function automatic crc_mat_t crc_build_matrix();
    crc_mat_t m;
    for (int unsigned i = 0; i < CrcWidth; i++) begin
      m[i] = crc_column(i);
    end
    return m;
  endfunction

  localparam crc_mat_t CRC_MAT = crc_build_matrix();

  // One full word step: XOR of the columns selected by the set bits.
  function automatic crc_word_t crc_word_step(input crc_word_t r);
    crc_word_t acc;
    acc = '0;
    for (int unsigned i = 0; i < CrcWidth; i++) begin
      if (r[i]) begin
        acc = acc ^ CRC_MAT[i];
      end
    end
    return acc;
  endfunction

endpackage

/* src/crc32_word_extended_byte_stream_core.sv */
// Top level of the byte-stream CRC-32 core with a one-word-step-per-byte update.
//
// Usage: message bytes enter on the input channel (in_valid / in_ready with
// data_byte and last_byte). Each accepted byte is XORed into the low bits of
// the running CRC register, which is then advanced by a full 32-bit word step
// of polynomial 0x04C11DB7 through a constant XOR network.
// On a byte marked last_byte, the final CRC (stepped value XOR all ones) is placed
// on the output channel (out_valid / out_ready with crc_value) and the
// register reloads all ones for the next message.
// Throughput: one byte per cycle while in_ready is high; the XOR network on the
// CRC register is what sets that figure. The CRC is registered into crc_value,
// or into the skid entry while the output is held.
// Reset clears the CRC register to all ones and empties the output stage.
// When the receiver stalls, results are held in a two-entry output stage; the
// input keeps taking bytes until both entries are full, and then in_ready
// drops until the receiver takes a word.
module crc32_word_extended_byte_stream_core
  import crc32wbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ByteWidth-1:0] data_byte,
  input  logic                 last_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CrcWidth-1:0]  crc_value
);

  crc_word_t crc_reg;
  crc_word_t crc_step;
  crc_word_t crc_final;
  crc_word_t skid_data;
  logic      skid_valid;
  logic      in_take;
  logic      push;
  logic      out_free;

  assign in_ready  = !skid_valid;
  assign in_take   = in_valid && in_ready;
  assign push      = in_take && last_byte;
  assign out_free  = !out_valid || out_ready;

  assign crc_step  = crc_word_step(crc_reg ^ {{(CrcWidth-ByteWidth){1'b0}}, data_byte});
  assign crc_final = crc_step ^ CRC_XOROUT;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg <= CRC_INIT;
    end else if (in_take) begin
      crc_reg <= last_byte ? CRC_INIT : crc_step;
    end
  end

  // Two-entry result stage; the skid entry fills only while the head is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        crc_value <= skid_data;
      end else if (push) begin
        crc_value <= crc_final;
      end
    end
    if (!out_free && push) begin
      skid_data <= crc_final;
    end
  end

endmodule

/* src/crc32wbs_checker.sv */
// Port-level checker for the byte-stream CRC core, bound to the top level.
module crc32wbs_checker
  import crc32wbs_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [ByteWidth-1:0] data_byte,
  input logic                 last_byte,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CrcWidth-1:0]  crc_value
);

  // A stalled result word stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(crc_value))
    else $error("result word changed while stalled");

  // Reset leaves the output channel empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // A result appears on an empty output only after a last word was taken.
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && last_byte))
    else $error("result word without a last input word");

  // The input stalls only while a result word is waiting, and a stalled input
  // word is still offered unchanged on the next cycle.
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |-> out_valid ##1 in_valid && $stable({data_byte, last_byte}))
    else $error("input stall without a waiting result or input word changed");

endmodule

bind crc32_word_extended_byte_stream_core crc32wbs_checker u_crc32wbs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .data_byte (data_byte),
  .last_byte (last_byte),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .crc_value (crc_value)
);
